// ===== src/swr_pkg.sv =====
// Shared constants for the sliding-window RMS core.
`default_nettype none
package swr_pkg;
    localparam int SAMPLE_W = 16;   // Q3.12 sample
    localparam int SQ_W     = 31;   // square of a 16-bit signed value
    localparam int RMS_W    = 16;
    localparam int FILL_W   = 9;
    localparam int ROOT_IN_W = 2 * RMS_W;   // radicand, padded to an even width
    localparam int SREM_W   = RMS_W + 1;    // root remainder, at most 2*root

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
endpackage
`default_nettype wire

// ===== src/swr_front.sv =====
// Front end: accepts items, maintains the window, count and running sum of squares.
`default_nettype none
module swr_front #(
    parameter int WINDOW = 256,
    parameter int AW     = 8,
    parameter int CW     = 9,
    parameter int SW     = 39
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_mode,
    input  wire logic signed [swr_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                     q_push,
    output logic [SW-1:0]                            q_sum,
    output logic [CW-1:0]                            q_cnt,
    input  wire logic                                q_full
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RD   = 3'b010,
        F_UPD  = 3'b100
    } front_state_t;

    front_state_t                      state_reg, state_next;
    logic [AW-1:0]                     pos_reg, pos_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [SW-1:0]                     sum_reg, sum_next;
    logic signed [swr_pkg::SAMPLE_W-1:0] sample_reg;
    logic [swr_pkg::SQ_W-1:0]          sq_new_reg, sq_old_reg;
    logic signed [swr_pkg::SAMPLE_W-1:0] mem [WINDOW];
    logic signed [swr_pkg::SAMPLE_W-1:0] rd_q;
    logic signed [2*swr_pkg::SAMPLE_W-1:0] prod_in, prod_old;
    logic                              accept, full, mem_we;

    assign accept   = s_valid && s_ready;
    assign full     = (cnt_reg == CW'(WINDOW));
    assign prod_in  = s_sample * s_sample;
    assign prod_old = rd_q * rd_q;
    assign mem_we   = (state_reg == F_UPD);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[pos_reg] <= sample_reg;
        end
        rd_q <= mem[pos_reg];
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        s_ready    = (state_reg == F_IDLE) && !q_full;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    if (s_mode == swr_pkg::MODE_CLEAR) begin
                        pos_next = '0;
                        cnt_next = '0;
                        sum_next = '0;
                        q_push   = 1'b1;
                    end else begin
                        state_next = F_RD;
                    end
                end
            end
            F_RD: begin
                state_next = F_UPD;
            end
            F_UPD: begin
                sum_next = sum_reg - SW'(sq_old_reg) + SW'(sq_new_reg);
                if (!full) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pos_reg == AW'(WINDOW - 1)) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
                q_push     = 1'b1;
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign q_sum = sum_next;
    assign q_cnt = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
            sq_new_reg <= prod_in[swr_pkg::SQ_W-1:0];
        end
        // oldest sample only leaves the sum once the window is full
        if (state_reg == F_RD) begin
            sq_old_reg <= full ? prod_old[swr_pkg::SQ_W-1:0] : '0;
        end
    end
endmodule
`default_nettype wire

// ===== src/swr_queue.sv =====
// Two-entry queue between front and back end.
`default_nettype none
module swr_queue #(
    parameter int DW = 48
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] wdata,
    output logic               full,
    input  wire logic          pop,
    output logic               nonempty,
    output logic [DW-1:0]      rdata
);
    logic [DW-1:0] mem [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    lvl_reg;

    assign full     = (lvl_reg == 2'd2);
    assign nonempty = (lvl_reg != 2'd0);
    assign rdata    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            lvl_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            lvl_reg <= lvl_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== src/swr_back.sv =====
// Back end: serial divide of sum by count, serial square root, output register.
`default_nettype none
module swr_back #(
    parameter int CW = 9,
    parameter int SW = 39
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_nonempty,
    output logic                                 q_pop,
    input  wire logic [SW-1:0]                   q_sum,
    input  wire logic [CW-1:0]                   q_cnt,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [swr_pkg::RMS_W-1:0]            m_rms_value,
    output logic [swr_pkg::FILL_W-1:0]           m_fill_level
);
    localparam int IW = $clog2(SW + 1);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SQRT = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t                      state_reg;
    logic [IW-1:0]                    iter_reg;
    logic [SW-1:0]                    dq_reg;
    logic [CW-1:0]                    rem_reg, dvs_reg;
    logic                             zero_reg;
    logic [swr_pkg::ROOT_IN_W-1:0]    v_reg;
    logic [swr_pkg::RMS_W-1:0]        root_reg;
    logic [swr_pkg::SREM_W-1:0]       srem_reg;
    logic                             m_valid_reg;
    logic [swr_pkg::RMS_W-1:0]        rms_reg;
    logic [swr_pkg::FILL_W-1:0]       fill_reg;

    logic [CW:0]                      dtrial, ddiff;
    logic                             dbit;
    logic [swr_pkg::SREM_W+1:0]       strial, sdiv, sdiff;
    logic                             sbit, out_free;

    assign dtrial = {rem_reg, dq_reg[SW-1]};
    assign dbit   = (dtrial >= {1'b0, dvs_reg});
    assign ddiff  = dtrial - {1'b0, dvs_reg};

    // radicand digit pair: remainder*4 + next two bits, against 4*root + 1
    assign strial = {srem_reg, v_reg[swr_pkg::ROOT_IN_W-1 -: 2]};
    assign sdiv   = {1'b0, root_reg, 2'b01};
    assign sbit   = (strial >= sdiv);
    assign sdiff  = strial - sdiv;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == B_IDLE) && q_nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == B_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (q_nonempty) begin
                        state_reg <= B_DIV;
                        iter_reg  <= '0;
                    end
                end
                B_DIV: begin
                    if (iter_reg == IW'(SW - 1)) begin
                        state_reg <= B_SQRT;
                        iter_reg  <= '0;
                    end else begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                B_SQRT: begin
                    if (iter_reg == IW'(swr_pkg::RMS_W - 1)) begin
                        state_reg <= B_OUT;
                    end else begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                dq_reg   <= q_sum;
                dvs_reg  <= q_cnt;
                rem_reg  <= '0;
                zero_reg <= (q_cnt == '0);
            end
            B_DIV: begin
                rem_reg <= dbit ? ddiff[CW-1:0] : dtrial[CW-1:0];
                dq_reg  <= {dq_reg[SW-2:0], dbit};
                if (iter_reg == IW'(SW - 1)) begin
                    // mean square never exceeds one full-scale square
                    v_reg    <= {1'b0, dq_reg[swr_pkg::SQ_W-2:0], dbit};
                    root_reg <= '0;
                    srem_reg <= '0;
                end
            end
            B_SQRT: begin
                srem_reg <= sbit ? sdiff[swr_pkg::SREM_W-1:0] : strial[swr_pkg::SREM_W-1:0];
                root_reg <= {root_reg[swr_pkg::RMS_W-2:0], sbit};
                v_reg    <= {v_reg[swr_pkg::ROOT_IN_W-3:0], 2'b00};
            end
            B_OUT: begin
                if (out_free) begin
                    rms_reg  <= zero_reg ? '0 : root_reg;
                    fill_reg <= swr_pkg::FILL_W'(dvs_reg);
                end
            end
            default: ;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_rms_value  = rms_reg;
    assign m_fill_level = fill_reg;
endmodule
`default_nettype wire

// ===== src/sliding_window_rms_core.sv =====
// Top level of the sliding-window RMS core.
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_mode, s_sample
//  m_      | out       | m_valid / m_ready | m_rms_value, m_fill_level
// Front end clears in idle; a push squares in idle, reads window RAM, then updates the sum.
// Back end (SW = 30 + log2 of WINDOW+1 sum bits) runs a one-bit-a-cycle divider over SW
// quotient bits, a 16-step root and the output load. The back end sets the rate.
// A two-entry queue lets the front run ahead; the input stalls when the queue is full.
// Synchronous active-low reset clears pointers, count and sum; the window RAM is not cleared.
`default_nettype none
module sliding_window_rms_core #(
    parameter int WINDOW = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_mode,
    input  wire logic signed [swr_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [swr_pkg::RMS_W-1:0]                m_rms_value,
    output logic [swr_pkg::FILL_W-1:0]               m_fill_level
);
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = 2 * swr_pkg::SAMPLE_W - 2 + CW;

    logic          q_push, q_full, q_pop, q_nonempty;
    logic [SW-1:0] f_sum, b_sum;
    logic [CW-1:0] f_cnt, b_cnt;

    swr_front #(.WINDOW(WINDOW), .AW(AW), .CW(CW), .SW(SW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_sample (s_sample),
        .q_push   (q_push),
        .q_sum    (f_sum),
        .q_cnt    (f_cnt),
        .q_full   (q_full)
    );

    swr_queue #(.DW(SW + CW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wdata    ({f_sum, f_cnt}),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .rdata    ({b_sum, b_cnt})
    );

    swr_back #(.CW(CW), .SW(SW)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_nonempty   (q_nonempty),
        .q_pop        (q_pop),
        .q_sum        (b_sum),
        .q_cnt        (b_cnt),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rms_value  (m_rms_value),
        .m_fill_level (m_fill_level)
    );
endmodule
`default_nettype wire
